// ===== sv/bvop_pkg.sv =====
// Shared types and constants for the bit vector operation unit.
package bvop_pkg;

  // Default geometry of the held vector
  localparam int WORDS_DEF     = 4;
  localparam int WORD_BITS_DEF = 64;

  // Command codes
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_SHR    = 3'd2,
    OP_SHL    = 3'd3,
    OP_FFS    = 3'd4,
    OP_FFZ    = 3'd5,
    OP_SLICE  = 3'd6,
    OP_CONTIG = 3'd7
  } opcode_t;

  // One command item
  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  word_select;
    logic [63:0] write_word;
    logic [8:0]  position;
    logic [6:0]  slice_length;
  } bvop_in_t;

  // One result item
  typedef struct packed {
    logic [63:0] result_word;
    logic [8:0]  bit_index;
    logic        found;
    logic        bits_lost;
  } bvop_out_t;

endpackage

// ===== sv/bvop_alu.sv =====
// Combinational command datapath: word access, shifts, bit searches, slice, run test.
module bvop_alu #(
  parameter int WORDS     = bvop_pkg::WORDS_DEF,
  parameter int WORD_BITS = bvop_pkg::WORD_BITS_DEF
) (
  input  logic [WORDS*WORD_BITS-1:0] vec,
  input  bvop_pkg::bvop_in_t         cmd,
  output logic [WORDS*WORD_BITS-1:0] vec_nxt,
  output bvop_pkg::bvop_out_t        res
);
  import bvop_pkg::*;

  localparam int WIDTH = WORDS * WORD_BITS;
  localparam int IDX_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]    ones;
  logic [WIDTH-1:0]    shl;
  logic [WIDTH-1:0]    kept_mask;
  logic [WIDTH-1:0]    start_mask;
  logic [WIDTH-1:0]    set_cand;
  logic [WIDTH-1:0]    zero_cand;
  logic [WIDTH-1:0]    rise;
  logic [WIDTH+63:0]   slice_ext;
  logic [63:0]         slice_mask;
  logic [63:0]         read_word;
  logic [IDX_W-1:0]    ffs_idx;
  logic [IDX_W-1:0]    ffz_idx;
  logic                ffs_hit;
  logic                contig;

  assign ones       = '1;
  assign shl        = vec << cmd.position;
  assign kept_mask  = ones >> cmd.position;
  assign start_mask = ones << cmd.position;
  assign set_cand   = vec & start_mask;
  assign zero_cand  = ~vec & start_mask;

  // Find lowest candidate bits; no hit leaves the width
  always_comb begin
    ffs_idx = IDX_W'(WIDTH);
    ffz_idx = IDX_W'(WIDTH);
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (set_cand[i]) begin
        ffs_idx = IDX_W'(i);
      end
      if (zero_cand[i]) begin
        ffz_idx = IDX_W'(i);
      end
    end
  end
  assign ffs_hit = |set_cand;

  // Single run: exactly one rising edge in the vector
  assign rise   = vec & ~(vec << 1);
  assign contig = (rise != '0) && ((rise & (rise - 1'b1)) == '0);

  // Slice: shift down, then keep the requested low bits
  assign slice_ext = {64'd0, vec} >> cmd.position;
  always_comb begin
    if (cmd.slice_length >= 7'd64) begin
      slice_mask = '1;
    end else begin
      slice_mask = (64'd1 << cmd.slice_length[5:0]) - 64'd1;
    end
  end

  // Select the addressed word for a read
  always_comb begin
    read_word = '0;
    for (int w = 0; w < WORDS; w++) begin
      if (w < 4 && cmd.word_select == 2'(w)) begin
        read_word = 64'(vec[w*WORD_BITS +: WORD_BITS]);
      end
    end
  end

  // Next vector contents
  always_comb begin
    vec_nxt = vec;
    unique case (cmd.opcode)
      OP_WRITE: begin
        for (int w = 0; w < WORDS; w++) begin
          if (w < 4 && cmd.word_select == 2'(w)) begin
            vec_nxt[w*WORD_BITS +: WORD_BITS] = cmd.write_word[WORD_BITS-1:0];
          end
        end
      end
      OP_SHR:  vec_nxt = vec >> cmd.position;
      OP_SHL:  vec_nxt = shl;
      default: vec_nxt = vec;
    endcase
  end

  // Result fields
  always_comb begin
    res = '0;
    unique case (cmd.opcode)
      OP_READ:   res.result_word = read_word;
      OP_SHL:    res.bits_lost   = |(vec & ~kept_mask);
      OP_FFS: begin
        res.bit_index = 9'(ffs_idx);
        res.found     = ffs_hit;
      end
      OP_FFZ:    res.bit_index   = 9'(ffz_idx);
      OP_SLICE:  res.result_word = slice_ext[63:0] & slice_mask;
      OP_CONTIG: res.found       = contig;
      default:   res = '0;
    endcase
  end

endmodule

// ===== sv/bit_vector_operation_unit.sv =====
// Top level of the bit vector operation unit: command and result registers, vector state.
//
//   Port group   Direction  Transfer when           Payload
//   in_*         input      in_valid && !in_stall   bvop_in_t  (one command)
//   out_*        output     out_valid && !out_stall bvop_out_t (one result)
//
// Each command passes through the command register and then the result register;
// one command per cycle is sustained while out_stall is low, set by the single pass of
// shift, priority encode and slice logic over the vector register.
// Reset clears the vector to zero and empties both registers.
// A stalled result holds; one more command may enter behind it, then in_stall rises.
module bit_vector_operation_unit #(
  parameter int WORDS     = bvop_pkg::WORDS_DEF,
  parameter int WORD_BITS = bvop_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bvop_pkg::bvop_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bvop_pkg::bvop_out_t out_data
);
  import bvop_pkg::*;

  localparam int WIDTH = WORDS * WORD_BITS;

  logic [WIDTH-1:0] vec_r;
  logic [WIDTH-1:0] vec_nxt;
  logic             cmd_valid_r;
  bvop_in_t         cmd_r;
  logic             out_valid_r;
  bvop_out_t        out_data_r;
  bvop_out_t        res;
  logic             advance;

  // Move the command to the result register when that register is free
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = cmd_valid_r && !advance;

  bvop_alu #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .vec     (vec_r),
    .cmd     (cmd_r),
    .vec_nxt (vec_nxt),
    .res     (res)
  );

  // Command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (!in_stall) begin
      cmd_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r <= in_data;
    end
  end

  // Result register and vector update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vec_r       <= '0;
    end else if (advance) begin
      out_valid_r <= cmd_valid_r;
      if (cmd_valid_r) begin
        vec_r <= vec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cmd_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
